### rtl/vmb_pkg.sv
// Shared types and constants of the VU meter ballistics block.
`default_nettype none
package vmb_pkg;

   localparam int SAMPLE_BITS   = 24;
   localparam int FRAME_BITS    = 8;
   localparam int AMP_BITS      = 26;
   localparam int INDEX_BITS    = 4;
   localparam int HOLD_BITS     = 16;
   localparam int COEF_BITS     = 32;
   localparam int TICKS_DEF     = 12;
   localparam int QUEUE_DEPTH   = 2;
   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;

   localparam logic [HOLD_BITS-1:0] HOLD_MS_RESET = HOLD_BITS'(1000);
   localparam logic signed [COEF_BITS-1:0] SCALE_Q30 = 32'sd1539675233;

   localparam logic [1:0] OP_SAMPLE  = 2'd0;
   localparam logic [1:0] OP_TICK    = 2'd1;
   localparam logic [1:0] OP_REFRESH = 2'd2;
   localparam logic [1:0] OP_LOAD    = 2'd3;

   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_B0     = 3'd0;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_A1     = 3'd1;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_COEF_A2     = 3'd2;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_HOLD_MS     = 3'd3;
   localparam logic [CSR_ADDR_BITS-1:0] CSR_PEAK_ENABLE = 3'd4;

   typedef struct packed {
      logic [1:0]                    opcode;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [INDEX_BITS-1:0]         tick_index;
      logic [AMP_BITS-1:0]           tick_amplitude;
      logic [FRAME_BITS-1:0]         tick_frame;
   } req_type;

   typedef struct packed {
      logic [FRAME_BITS-1:0] needle_frame;
      logic [FRAME_BITS-1:0] held_frame;
      logic                  show_held;
   } rsp_type;

   typedef struct packed {
      logic signed [COEF_BITS-1:0] coef_b0;
      logic signed [COEF_BITS-1:0] coef_a1;
      logic signed [COEF_BITS-1:0] coef_a2;
      logic [HOLD_BITS-1:0]        hold_ms;
      logic                        peak_enable;
   } cfg_type;

   typedef enum logic [2:0] {
      CMD_NOP,
      CMD_SAMPLE,
      CMD_TICK,
      CMD_REFRESH,
      CMD_LOAD
   } cmd_kind_type;

   typedef struct packed {
      cmd_kind_type                  kind;
      logic signed [SAMPLE_BITS-1:0] sample;
      logic [INDEX_BITS-1:0]         tick_index;
      logic [AMP_BITS-1:0]           amp;
      logic [FRAME_BITS-1:0]         frame;
   } cmd_type;

endpackage
`default_nettype wire

### rtl/vmb_front.sv
// Input stage that accepts transactions and classifies them into commands.
`default_nettype none
module vmb_front import vmb_pkg::*; #(
   parameter int TICKS = TICKS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    req_valid,
   output logic         req_ready,
   input  wire req_type req,
   output logic         push_valid,
   input  wire logic    push_ready,
   output cmd_type      push_cmd
);

   logic    valid_ff;
   cmd_type cmd_ff;
   cmd_type cmd_in;

   always_comb begin
      cmd_in.sample     = req.sample;
      cmd_in.tick_index = req.tick_index;
      cmd_in.amp        = req.tick_amplitude;
      cmd_in.frame      = req.tick_frame;
      unique case (req.opcode)
         OP_SAMPLE:  cmd_in.kind = CMD_SAMPLE;
         OP_TICK:    cmd_in.kind = CMD_TICK;
         OP_REFRESH: cmd_in.kind = CMD_REFRESH;
         OP_LOAD:    cmd_in.kind = (32'(req.tick_index) < TICKS) ? CMD_LOAD : CMD_NOP;
         default:    cmd_in.kind = CMD_NOP;
      endcase
   end

   assign req_ready  = !valid_ff || push_ready;
   assign push_valid = valid_ff;
   assign push_cmd   = cmd_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (req_ready) begin
         valid_ff <= req_valid;
      end
      if (req_valid && req_ready) begin
         cmd_ff <= cmd_in;
      end
   end

endmodule
`default_nettype wire

### rtl/vmb_queue.sv
// Short command queue between the input stage and the execution unit.
`default_nettype none
module vmb_queue import vmb_pkg::*; (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire logic    push_valid,
   output logic         push_ready,
   input  wire cmd_type push_cmd,
   output logic         pop_valid,
   input  wire logic    pop_ready,
   output cmd_type      pop_cmd
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   cmd_type               slot_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]   wr_ptr_ff;
   logic [PTR_BITS-1:0]   rd_ptr_ff;
   logic [CNT_BITS-1:0]   count_ff;
   logic                  do_push;
   logic                  do_pop;

   assign push_ready = (count_ff != CNT_BITS'(QUEUE_DEPTH));
   assign pop_valid  = (count_ff != '0);
   assign pop_cmd    = slot_ff[rd_ptr_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            wr_ptr_ff <= (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_cmd;
      end
   end

endmodule
`default_nettype wire

### rtl/vmb_back.sv
// Execution unit: filter, level scaling, table interpolation and peak hold.
`default_nettype none
module vmb_back import vmb_pkg::*; #(
   parameter int TICKS = TICKS_DEF
) (
   input  wire logic    clock,
   input  wire logic    reset,
   input  wire cfg_type cfg,
   input  wire logic    cmd_valid,
   output logic         cmd_ready,
   input  wire cmd_type cmd,
   output logic         rsp_valid,
   input  wire logic    rsp_ready,
   output rsp_type      rsp
);

   localparam int TIDX_BITS  = (TICKS > 1) ? $clog2(TICKS) : 1;
   localparam int ACC_BITS   = 40;
   localparam int PROD_BITS  = 2 * COEF_BITS;
   localparam int LVL_SHIFT  = SAMPLE_BITS + 6;
   localparam int LVL_BITS   = PROD_BITS - 2 - LVL_SHIFT;
   localparam int CNT_BITS   = $clog2(FRAME_BITS + 1);
   localparam logic signed [ACC_BITS-1:0] ACC_MAX = ACC_BITS'(64'sd2147483647);
   localparam logic signed [ACC_BITS-1:0] ACC_MIN = ACC_BITS'(-64'sd2147483648);

   typedef enum logic [3:0] {
      ST_IDLE, ST_FILT, ST_SAT, ST_REF_MUL, ST_LEVEL, ST_SCAN,
      ST_DIV_MUL, ST_DIV_SET, ST_DIV, ST_FRAME, ST_HOLD
   } state_type;

   state_type                     state_ff;
   cmd_type                       cur_ff;
   logic [2:0]                    step_ff;
   logic signed [ACC_BITS-1:0]    acc_ff;
   logic signed [PROD_BITS-1:0]   prod_ff;
   logic signed [SAMPLE_BITS-1:0] xh0_ff;
   logic signed [SAMPLE_BITS-1:0] xh1_ff;
   logic signed [COEF_BITS-1:0]   y_ff;
   logic signed [COEF_BITS-1:0]   yh_ff;
   logic [LVL_BITS-1:0]           level_ff;
   logic [TIDX_BITS-1:0]          idx_ff;
   logic [AMP_BITS-1:0]           prev_amp_ff;
   logic [FRAME_BITS-1:0]         prev_frame_ff;
   logic [AMP_BITS-1:0]           off_ff;
   logic [AMP_BITS-1:0]           den_ff;
   logic signed [FRAME_BITS:0]    dif_ff;
   logic                          neg_ff;
   logic [AMP_BITS-1:0]           rem_ff;
   logic [FRAME_BITS-1:0]         quo_ff;
   logic [CNT_BITS-1:0]           cnt_ff;
   logic [FRAME_BITS-1:0]         frame_ff;
   logic [FRAME_BITS-1:0]         hold_frame_ff;
   logic [HOLD_BITS-1:0]          hold_elapsed_ff;
   logic                          rsp_valid_ff;
   rsp_type                       rsp_ff;

   logic [AMP_BITS-1:0]           amp_mem [TICKS];
   logic [FRAME_BITS-1:0]         frame_mem [TICKS];

   logic signed [COEF_BITS-1:0]   mul_a;
   logic signed [COEF_BITS-1:0]   mul_b;
   logic signed [PROD_BITS-1:0]   mul_p;
   logic signed [ACC_BITS-1:0]    term;
   logic signed [ACC_BITS-1:0]    y_sat;
   logic [AMP_BITS-1:0]           rd_amp;
   logic [FRAME_BITS-1:0]         rd_frame;
   logic [PROD_BITS-1:0]          mag;
   logic [AMP_BITS:0]             shifted;
   logic                          ge;
   logic [FRAME_BITS-1:0]         q_ceil;

   always_comb begin
      mul_a = $signed({{(COEF_BITS - AMP_BITS){1'b0}}, off_ff});
      mul_b = COEF_BITS'(dif_ff);
      if (state_ff == ST_FILT) begin
         case (step_ff)
            3'd0: begin
               mul_a = cfg.coef_b0;
               mul_b = COEF_BITS'(cur_ff.sample);
            end
            3'd1: begin
               mul_a = cfg.coef_b0;
               mul_b = COEF_BITS'(xh0_ff);
            end
            3'd2: begin
               mul_a = cfg.coef_b0;
               mul_b = COEF_BITS'(xh1_ff);
            end
            3'd3: begin
               mul_a = cfg.coef_a1;
               mul_b = y_ff;
            end
            default: begin
               mul_a = cfg.coef_a2;
               mul_b = yh_ff;
            end
         endcase
      end else if (state_ff == ST_REF_MUL) begin
         mul_a = y_ff;
         mul_b = SCALE_Q30;
      end
   end

   assign mul_p = mul_a * mul_b;

   // The middle feed-forward tap carries the factor of two as a smaller shift.
   assign term = (step_ff == 3'd2) ? ACC_BITS'(prod_ff >>> 29) : ACC_BITS'(prod_ff >>> 30);

   always_comb begin
      if (acc_ff > ACC_MAX) begin
         y_sat = ACC_MAX;
      end else if (acc_ff < ACC_MIN) begin
         y_sat = ACC_MIN;
      end else begin
         y_sat = acc_ff;
      end
   end

   assign rd_amp   = amp_mem[idx_ff];
   assign rd_frame = frame_mem[idx_ff];
   assign mag      = prod_ff[PROD_BITS-1] ? PROD_BITS'(-prod_ff) : PROD_BITS'(prod_ff);
   assign shifted  = {rem_ff, quo_ff[FRAME_BITS-1]};
   assign ge       = (shifted >= {1'b0, den_ff});
   assign q_ceil   = quo_ff + FRAME_BITS'(rem_ff != '0);

   assign cmd_ready = (state_ff == ST_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp       = rsp_ff;

   always_ff @(posedge clock) begin
      if (cmd_valid && cmd_ready && cmd.kind == CMD_LOAD) begin
         amp_mem[cmd.tick_index[TIDX_BITS-1:0]]   <= cmd.amp;
         frame_mem[cmd.tick_index[TIDX_BITS-1:0]] <= cmd.frame;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         xh0_ff          <= '0;
         xh1_ff          <= '0;
         y_ff            <= '0;
         yh_ff           <= '0;
         hold_frame_ff   <= '0;
         hold_elapsed_ff <= '0;
         rsp_valid_ff    <= 1'b0;
      end else begin
         if (rsp_valid_ff && rsp_ready && state_ff != ST_HOLD) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (cmd_valid) begin
                  cur_ff  <= cmd;
                  step_ff <= '0;
                  case (cmd.kind)
                     CMD_SAMPLE:  state_ff <= ST_FILT;
                     CMD_REFRESH: state_ff <= ST_REF_MUL;
                     CMD_TICK: begin
                        if (hold_elapsed_ff != '1) begin
                           hold_elapsed_ff <= hold_elapsed_ff + 1'b1;
                        end
                     end
                     default: ;
                  endcase
               end
            end
            ST_FILT: begin
               prod_ff <= mul_p;
               step_ff <= step_ff + 1'b1;
               if (step_ff == 3'd0) begin
                  acc_ff <= '0;
               end else if (step_ff >= 3'd4) begin
                  acc_ff <= acc_ff - term;
               end else begin
                  acc_ff <= acc_ff + term;
               end
               if (step_ff == 3'd5) begin
                  state_ff <= ST_SAT;
               end
            end
            ST_SAT: begin
               xh1_ff   <= xh0_ff;
               xh0_ff   <= cur_ff.sample;
               yh_ff    <= y_ff;
               y_ff     <= COEF_BITS'(y_sat);
               state_ff <= ST_IDLE;
            end
            ST_REF_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_LEVEL;
            end
            ST_LEVEL: begin
               level_ff      <= (y_ff > 0) ? LVL_BITS'(prod_ff >>> LVL_SHIFT) : '0;
               idx_ff        <= '0;
               prev_amp_ff   <= '0;
               prev_frame_ff <= '0;
               state_ff      <= ST_SCAN;
            end
            ST_SCAN: begin
               if (level_ff < LVL_BITS'(rd_amp)) begin
                  off_ff   <= AMP_BITS'(level_ff) - prev_amp_ff;
                  den_ff   <= rd_amp - prev_amp_ff;
                  dif_ff   <= $signed({1'b0, rd_frame}) - $signed({1'b0, prev_frame_ff});
                  state_ff <= ST_DIV_MUL;
               end else if (idx_ff == TIDX_BITS'(TICKS - 1)) begin
                  frame_ff <= rd_frame;
                  state_ff <= ST_HOLD;
               end else begin
                  prev_amp_ff   <= rd_amp;
                  prev_frame_ff <= rd_frame;
                  idx_ff        <= idx_ff + 1'b1;
               end
            end
            ST_DIV_MUL: begin
               prod_ff  <= mul_p;
               state_ff <= ST_DIV_SET;
            end
            ST_DIV_SET: begin
               neg_ff   <= prod_ff[PROD_BITS-1];
               rem_ff   <= AMP_BITS'(mag >> FRAME_BITS);
               quo_ff   <= mag[FRAME_BITS-1:0];
               cnt_ff   <= '0;
               state_ff <= ST_DIV;
            end
            ST_DIV: begin
               rem_ff <= ge ? AMP_BITS'(shifted - {1'b0, den_ff}) : AMP_BITS'(shifted);
               quo_ff <= {quo_ff[FRAME_BITS-2:0], ge};
               cnt_ff <= cnt_ff + 1'b1;
               if (cnt_ff == CNT_BITS'(FRAME_BITS - 1)) begin
                  state_ff <= ST_FRAME;
               end
            end
            ST_FRAME: begin
               frame_ff <= neg_ff ? prev_frame_ff - q_ceil : prev_frame_ff + quo_ff;
               state_ff <= ST_HOLD;
            end
            ST_HOLD: begin
               if (!rsp_valid_ff || rsp_ready) begin
                  rsp_valid_ff        <= 1'b1;
                  rsp_ff.needle_frame <= frame_ff;
                  if (frame_ff > hold_frame_ff || hold_elapsed_ff >= cfg.hold_ms) begin
                     hold_frame_ff     <= frame_ff;
                     hold_elapsed_ff   <= '0;
                     rsp_ff.held_frame <= frame_ff;
                     rsp_ff.show_held  <= 1'b0;
                  end else begin
                     rsp_ff.held_frame <= hold_frame_ff;
                     rsp_ff.show_held  <= cfg.peak_enable &&
                                          ((hold_frame_ff - frame_ff) > FRAME_BITS'(1));
                  end
                  state_ff <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

endmodule
`default_nettype wire

### rtl/vu_meter_ballistics.sv
// Top level of the VU meter needle ballistics block.
//
// Input transactions on req_ carry an opcode: a sample runs the second-order
// ballistics filter, a millisecond tick advances the peak hold timer, a load
// writes one entry of the tick table, and a refresh produces one transaction
// on rsp_ with the needle frame, the held frame and whether to show it.
// Registers are written through csr_, which is always ready; write them only
// while the block is idle.
// An input register and a two-entry queue feed one execution unit that works
// on one command at a time with a single shared 32 by 32 multiplier.
// In that unit a sample steps through the filter taps in turn, a tick or load
// completes on acceptance, and a refresh scans at most TICKS tick table entries
// and then interpolates with the bit-serial divider. Each command passes the
// input register and the queue before it reaches the unit.
// While the receiver stalls, the response is held and the unit keeps running
// non-refresh commands; a second refresh waits for the response register.
// Reset is synchronous and clears filter state, peak hold and registers to
// their defaults; the tick table must be loaded before the first refresh.
`default_nettype none
module vu_meter_ballistics import vmb_pkg::*; #(
   parameter int TICKS = TICKS_DEF
) (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire req_type                  req,
   output logic                          rsp_valid,
   input  wire logic                     rsp_ready,
   output rsp_type                       rsp,
   input  wire logic                     csr_valid,
   output logic                          csr_ready,
   input  wire logic [CSR_ADDR_BITS-1:0] csr_addr,
   input  wire logic [CSR_DATA_BITS-1:0] csr_wdata
);

   cfg_type cfg_ff;
   logic    push_valid;
   logic    push_ready;
   cmd_type push_cmd;
   logic    pop_valid;
   logic    pop_ready;
   cmd_type pop_cmd;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.coef_b0     <= '0;
         cfg_ff.coef_a1     <= '0;
         cfg_ff.coef_a2     <= '0;
         cfg_ff.hold_ms     <= HOLD_MS_RESET;
         cfg_ff.peak_enable <= 1'b0;
      end else if (csr_valid) begin
         unique case (csr_addr)
            CSR_COEF_B0:     cfg_ff.coef_b0     <= COEF_BITS'(csr_wdata);
            CSR_COEF_A1:     cfg_ff.coef_a1     <= COEF_BITS'(csr_wdata);
            CSR_COEF_A2:     cfg_ff.coef_a2     <= COEF_BITS'(csr_wdata);
            CSR_HOLD_MS:     cfg_ff.hold_ms     <= csr_wdata[HOLD_BITS-1:0];
            CSR_PEAK_ENABLE: cfg_ff.peak_enable <= csr_wdata[0];
            default: ;
         endcase
      end
   end

   vmb_front #(.TICKS(TICKS)) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req        (req),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd)
   );

   vmb_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_ready (push_ready),
      .push_cmd   (push_cmd),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_cmd    (pop_cmd)
   );

   vmb_back #(.TICKS(TICKS)) u_back (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg_ff),
      .cmd_valid (pop_valid),
      .cmd_ready (pop_ready),
      .cmd       (pop_cmd),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp       (rsp)
   );

   a_held_not_below: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp.held_frame >= rsp.needle_frame)
      else $error("held frame below needle frame");

   a_show_gap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.show_held |->
         (FRAME_BITS + 1)'(rsp.held_frame) > (FRAME_BITS + 1)'(rsp.needle_frame) + 1'b1)
      else $error("held needle shown without a gap of two frames");

   a_show_enabled: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp.show_held |-> cfg_ff.peak_enable)
      else $error("held needle shown while peak display is disabled");

endmodule
`default_nettype wire
